// ----- hdl/x86_imul_encoder_top_defines.svh -----
// Assertion macros shared by the IMUL encoder.
`ifndef X86_IMUL_ENCODER_TOP_DEFINES_SVH
`define X86_IMUL_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define X86I_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define X86I_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/x86i_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package x86i_pkg;

  localparam int FRAME_BYTES = 11;

  // operand kind mask bits
  localparam int K_BYTE  = 0;
  localparam int K_WORD  = 1;
  localparam int K_QWORD = 2;
  localparam int K_MEM   = 3;
  localparam int K_GPREG = 4;
  localparam int K_CONST = 5;

  localparam logic [7:0] OP_REXW     = 8'h48;
  localparam logic [7:0] OP_OPSIZE   = 8'h66;
  localparam logic [7:0] OP_GRP3_B   = 8'hf6;
  localparam logic [7:0] OP_GRP3_V   = 8'hf7;
  localparam logic [7:0] MODRM_MEM1  = 8'h28;
  localparam logic [7:0] MODRM_REG1  = 8'he8;
  localparam logic [7:0] OP_IMUL_IZ  = 8'h69;
  localparam logic [7:0] OP_IMUL_IB  = 8'h6b;
  localparam logic [7:0] OP_ESC      = 8'h0f;
  localparam logic [7:0] OP_IMUL_RM  = 8'haf;
  localparam logic [7:0] MOD_DISP32  = 8'h80;
  localparam logic [7:0] MOD_DISP8   = 8'h40;
  localparam logic [7:0] MOD_REG     = 8'hc0;
  localparam logic [7:0] RM_SIB      = 8'h04;
  localparam logic [7:0] RM_DISP32   = 8'h05;

  localparam logic [6:0] CODE_SIZE_RESET = 7'd32;
  localparam logic [6:0] CODE_SIZE_64    = 7'd64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  count;
    logic [5:0]  k0;
    logic [5:0]  k1;
    logic        c2;
    logic [2:0]  r0;
    logic [2:0]  b0;
    logic [2:0]  r1;
    logic [3:0]  b1;
    logic [3:0]  x1;
    logic [31:0] disp;
    logic [63:0] imm;
    logic        sentinel;
  } item_t;

  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [3:0]                  count;
    status_t                     status;
  } frame_t;

endpackage

`default_nettype wire

// ----- hdl/x86i_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface x86i_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operand_count;
  logic [5:0]         op0_kind;
  logic [5:0]         op1_kind;
  logic               op2_is_constant;
  logic [2:0]         op0_reg;
  logic [2:0]         op0_base_reg;
  logic [2:0]         op1_reg;
  logic [3:0]         op1_base_reg;
  logic [3:0]         op1_index_reg;
  logic signed [31:0] op1_displacement;
  logic [63:0]        const_magnitude;
  logic               const_negative;

  modport source (
    output valid, operand_count, op0_kind, op1_kind, op2_is_constant, op0_reg,
           op0_base_reg, op1_reg, op1_base_reg, op1_index_reg, op1_displacement,
           const_magnitude, const_negative,
    input  ready
  );
  modport sink (
    input  valid, operand_count, op0_kind, op1_kind, op2_is_constant, op0_reg,
           op0_base_reg, op1_reg, op1_base_reg, op1_index_reg, op1_displacement,
           const_magnitude, const_negative,
    output ready
  );
endinterface

interface x86i_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic [1:0] status;

  modport source (output valid, out_byte, last, status, input ready);
  modport sink (input valid, out_byte, last, status, output ready);
endinterface

interface x86i_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/x86i_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

module x86i_encoder (
  input  wire x86i_pkg::item_t  item,
  input  wire logic             cs64,
  output x86i_pkg::frame_t      frame
);

  logic [7:0] bv [x86i_pkg::FRAME_BYTES];
  logic [3:0] n;
  logic       b1u;
  logic       x1u;
  logic       imm_ge;
  logic       imm_le;
  logic       imm_hi;
  logic       disp_nz;
  logic       disp_big;
  logic [7:0] reg_fld;
  logic [7:0] mod_disp;
  logic       bad_count;
  logic       sent_err;

  assign b1u      = item.b1[3];
  assign x1u      = item.x1[3];
  assign imm_ge   = !item.imm[63] && (|item.imm[62:7]);
  assign imm_le   = item.imm[63] && (!(&item.imm[62:7]) || (item.imm[6:0] == 7'd0));
  assign imm_hi   = cs64 && !item.imm[63] && (|item.imm[62:32]);
  assign disp_nz  = |item.disp;
  assign disp_big = item.disp[31] ? (!(&item.disp[30:7]) || (item.disp[6:0] == 7'd0))
                                  : (|item.disp[30:7]);
  assign reg_fld  = {2'b00, item.r0, 3'b000};
  assign mod_disp = (disp_big ? x86i_pkg::MOD_DISP32 : x86i_pkg::MOD_DISP8) | reg_fld;
  assign bad_count = (item.count == 3'd0) || (item.count > 3'd3);
  assign sent_err  = (item.count == 3'd2) && item.k0[x86i_pkg::K_GPREG] &&
                     item.k1[x86i_pkg::K_CONST] && item.sentinel;

  always_comb begin
    for (int i = 0; i < x86i_pkg::FRAME_BYTES; i++) begin
      bv[i] = 8'h00;
    end
    n = 4'd0;

    if (item.k0[x86i_pkg::K_QWORD]) begin
      bv[n] = x86i_pkg::OP_REXW; n = n + 4'd1;
    end

    case (item.count)
      3'd1: begin
        if (item.k0[x86i_pkg::K_WORD]) begin
          bv[n] = x86i_pkg::OP_OPSIZE; n = n + 4'd1;
        end
        bv[n] = item.k0[x86i_pkg::K_BYTE] ? x86i_pkg::OP_GRP3_B : x86i_pkg::OP_GRP3_V;
        n = n + 4'd1;
        bv[n] = item.k0[x86i_pkg::K_MEM] ? (x86i_pkg::MODRM_MEM1 | {5'd0, item.b0})
                                         : (x86i_pkg::MODRM_REG1 | {5'd0, item.r0});
        n = n + 4'd1;
      end
      3'd2: begin
        if (item.k0[x86i_pkg::K_GPREG]) begin
          if (item.k1[x86i_pkg::K_CONST]) begin
            bv[n] = imm_ge ? x86i_pkg::OP_IMUL_IZ : x86i_pkg::OP_IMUL_IB; n = n + 4'd1;
            bv[n] = x86i_pkg::MOD_REG | reg_fld | {5'd0, item.r0}; n = n + 4'd1;
            bv[n] = item.imm[7:0]; n = n + 4'd1;
            if (imm_ge) begin
              bv[n] = item.imm[15:8];  n = n + 4'd1;
              bv[n] = item.imm[23:16]; n = n + 4'd1;
              bv[n] = item.imm[31:24]; n = n + 4'd1;
            end
            if (imm_hi) begin
              bv[n] = item.imm[39:32]; n = n + 4'd1;
              bv[n] = item.imm[47:40]; n = n + 4'd1;
              bv[n] = item.imm[55:48]; n = n + 4'd1;
              bv[n] = item.imm[63:56]; n = n + 4'd1;
            end
          end else if (item.k1[x86i_pkg::K_MEM]) begin
            bv[n] = x86i_pkg::OP_ESC;     n = n + 4'd1;
            bv[n] = x86i_pkg::OP_IMUL_RM; n = n + 4'd1;
            if (!b1u) begin
              if (disp_nz) begin
                bv[n] = mod_disp | {5'd0, item.b1[2:0]}; n = n + 4'd1;
                bv[n] = item.disp[7:0]; n = n + 4'd1;
                if (disp_big) begin
                  bv[n] = item.disp[15:8];  n = n + 4'd1;
                  bv[n] = item.disp[23:16]; n = n + 4'd1;
                  bv[n] = item.disp[31:24]; n = n + 4'd1;
                end
              end else if (!x1u) begin
                bv[n] = x86i_pkg::RM_SIB | reg_fld; n = n + 4'd1;
                bv[n] = {2'b00, item.x1[2:0], item.b1[2:0]}; n = n + 4'd1;
              end else begin
                bv[n] = reg_fld | {5'd0, item.b1[2:0]}; n = n + 4'd1;
              end
            end else begin
              bv[n] = reg_fld | x86i_pkg::RM_DISP32; n = n + 4'd1;
              bv[n] = item.imm[7:0];   n = n + 4'd1;
              bv[n] = item.imm[15:8];  n = n + 4'd1;
              bv[n] = item.imm[23:16]; n = n + 4'd1;
              bv[n] = item.imm[31:24]; n = n + 4'd1;
            end
          end else if (item.k1[x86i_pkg::K_GPREG]) begin
            bv[n] = x86i_pkg::OP_ESC;     n = n + 4'd1;
            bv[n] = x86i_pkg::OP_IMUL_RM; n = n + 4'd1;
            bv[n] = x86i_pkg::MOD_REG | reg_fld | {5'd0, item.r1}; n = n + 4'd1;
          end
        end
      end
      3'd3: begin
        if (item.k0[x86i_pkg::K_GPREG] && item.c2 &&
            (item.k1[x86i_pkg::K_GPREG] || item.k1[x86i_pkg::K_MEM])) begin
          bv[n] = x86i_pkg::OP_IMUL_IB; n = n + 4'd1;
          if (item.k1[x86i_pkg::K_MEM]) begin
            if (!x1u) begin
              bv[n] = x86i_pkg::RM_SIB | reg_fld; n = n + 4'd1;
              bv[n] = {2'b00, item.x1[2:0], item.b1[2:0]}; n = n + 4'd1;
            end else if (disp_nz) begin
              // base register is left out of this form
              bv[n] = mod_disp; n = n + 4'd1;
              bv[n] = item.disp[7:0]; n = n + 4'd1;
              if (disp_big) begin
                bv[n] = item.disp[15:8];  n = n + 4'd1;
                bv[n] = item.disp[23:16]; n = n + 4'd1;
                bv[n] = item.disp[31:24]; n = n + 4'd1;
              end
            end else begin
              bv[n] = reg_fld | {5'd0, item.b1[2:0]}; n = n + 4'd1;
            end
          end else begin
            bv[n] = x86i_pkg::MOD_REG | reg_fld | {5'd0, item.r1}; n = n + 4'd1;
          end
          bv[n] = item.imm[7:0]; n = n + 4'd1;
          if (imm_ge || imm_le) begin
            bv[n] = item.imm[15:8];  n = n + 4'd1;
            bv[n] = item.imm[23:16]; n = n + 4'd1;
            bv[n] = item.imm[31:24]; n = n + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    frame.bytes  = '0;
    frame.count  = 4'd1;
    frame.status = x86i_pkg::ST_OK;
    if (bad_count || sent_err) begin
      frame.status = x86i_pkg::ST_ERR;
    end else if (n == 4'd0) begin
      frame.status = x86i_pkg::ST_EMPTY;
    end else begin
      frame.count = n;
      for (int i = 0; i < x86i_pkg::FRAME_BYTES; i++) begin
        frame.bytes[i] = bv[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/x86i_serializer.sv -----
`timescale 1ns / 1ps
`default_nettype none

module x86i_serializer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire x86i_pkg::frame_t  frame,
  input  wire logic              frame_valid,
  output logic                   frame_ready,
  x86i_out_if.source             out_ch
);

  logic                        vld_r, vld_nxt;
  logic [3:0]                  rem_r, rem_nxt;
  logic [x86i_pkg::FRAME_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        pop;
  logic                        at_last;
  logic                        take;

  assign at_last     = (rem_r == 4'd1);
  assign pop         = vld_r && out_ch.ready;
  assign frame_ready = !vld_r || (pop && at_last);
  assign take        = frame_valid && frame_ready;

  always_comb begin
    vld_nxt    = vld_r;
    rem_nxt    = rem_r;
    bytes_nxt  = bytes_r;
    status_nxt = status_r;
    if (take) begin
      vld_nxt    = 1'b1;
      rem_nxt    = frame.count;
      bytes_nxt  = frame.bytes;
      status_nxt = frame.status;
    end else if (pop) begin
      if (at_last) begin
        vld_nxt = 1'b0;
      end
      rem_nxt   = rem_r - 4'd1;
      bytes_nxt = {8'h00, bytes_r[x86i_pkg::FRAME_BYTES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= 4'd0;
    end else begin
      vld_r <= vld_nxt;
      rem_r <= rem_nxt;
    end
    bytes_r  <= bytes_nxt;
    status_r <= status_nxt;
  end

  assign out_ch.valid    = vld_r;
  assign out_ch.out_byte = bytes_r[0];
  assign out_ch.last     = at_last;
  assign out_ch.status   = status_r;

endmodule

`default_nettype wire

// ----- hdl/x86_imul_encoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   one IMUL instruction description
// out_ch   out  valid/ready   out_byte, last, status
// cfg_ch   in   valid/ready   code_size_bits (always ready)
//
// An item is captured into the input register, encoded combinationally and
// loaded into the byte buffer, then shifted out one byte per cycle while
// out_ch.ready is high. A new item is taken while the previous one is still
// draining. Synchronous active-low reset clears the valid flags and sets
// code_size_bits to 32. Output stalls back up into the input register and
// then into in_ch.ready.

`include "x86_imul_encoder_top_defines.svh"

module x86_imul_encoder_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  x86i_in_if.sink    in_ch,
  x86i_out_if.source out_ch,
  x86i_cfg_if.sink   cfg_ch
);

  logic                   a_vld_r, a_vld_nxt;
  x86i_pkg::item_t        item_r, item_nxt;
  logic [6:0]             code_size_r, code_size_nxt;
  logic                   in_take;
  logic                   ser_ready;
  x86i_pkg::frame_t       enc_frame;
  logic                   cs64;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !a_vld_r || ser_ready;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cs64         = (code_size_r == x86i_pkg::CODE_SIZE_64);

  always_comb begin
    code_size_nxt = code_size_r;
    if (cfg_ch.valid) begin
      code_size_nxt = cfg_ch.data;
    end
    a_vld_nxt = a_vld_r;
    if (in_take) begin
      a_vld_nxt = 1'b1;
    end else if (ser_ready) begin
      a_vld_nxt = 1'b0;
    end
    item_nxt = item_r;
    if (in_take) begin
      item_nxt.count    = in_ch.operand_count;
      item_nxt.k0       = in_ch.op0_kind;
      item_nxt.k1       = in_ch.op1_kind;
      item_nxt.c2       = in_ch.op2_is_constant;
      item_nxt.r0       = in_ch.op0_reg;
      item_nxt.b0       = in_ch.op0_base_reg;
      item_nxt.r1       = in_ch.op1_reg;
      item_nxt.b1       = in_ch.op1_base_reg;
      item_nxt.x1       = in_ch.op1_index_reg;
      item_nxt.disp     = unsigned'(in_ch.op1_displacement);
      item_nxt.imm      = in_ch.const_negative ? (64'd0 - in_ch.const_magnitude)
                                               : in_ch.const_magnitude;
      item_nxt.sentinel = &in_ch.const_magnitude;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      code_size_r <= x86i_pkg::CODE_SIZE_RESET;
    end else begin
      a_vld_r     <= a_vld_nxt;
      code_size_r <= code_size_nxt;
    end
    item_r <= item_nxt;
  end

  x86i_encoder u_enc (
    .item  (item_r),
    .cs64  (cs64),
    .frame (enc_frame)
  );

  x86i_serializer u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame       (enc_frame),
    .frame_valid (a_vld_r),
    .frame_ready (ser_ready),
    .out_ch      (out_ch)
  );

  `X86I_ASSERT_NOW(a_err_single, out_ch.valid && (out_ch.status != x86i_pkg::ST_OK), out_ch.last && (out_ch.out_byte == 8'h00), "error or empty status must be a single zero byte")
  `X86I_ASSERT_NOW(a_frame_len, a_vld_r, (enc_frame.count != 4'd0) && (enc_frame.count <= 4'd11), "encoded length out of range")
  `X86I_ASSERT_NEXT(a_hold_item, a_vld_r && !ser_ready, a_vld_r && $stable(item_r), "pending item lost while serializer busy")

endmodule

`default_nettype wire
